[src/ahmc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ahmc_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned SwW   = 8;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    MODE_INACTIVE = 2'd0,
    MODE_AUTO     = 2'd1,
    MODE_OFF      = 2'd2,
    MODE_ON       = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    SUB_NONE   = 3'd0,
    SUB_ENTER  = 3'd1,
    SUB_OFF    = 3'd2,
    SUB_ON     = 3'd3,
    SUB_TO_OFF = 3'd4,
    SUB_TO_ON  = 3'd5
  } sub_t;

  localparam logic [SwW-1:0] SW_OFF  = 8'd0;
  localparam logic [SwW-1:0] SW_ON   = 8'd1;
  localparam logic [SwW-1:0] SW_AUTO = 8'd2;

  localparam logic [CfgIdxW-1:0] CFG_ON_THRESHOLD  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_OFF_THRESHOLD = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DELAY_TO_ON   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DELAY_TO_OFF  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TICK_PERIOD   = 3'd4;

  localparam logic [DataW-1:0] RST_ON_THRESHOLD  = 16'd70;
  localparam logic [DataW-1:0] RST_OFF_THRESHOLD = 16'd60;
  localparam logic [DataW-1:0] RST_DELAY_TO_ON   = 16'd1000;
  localparam logic [DataW-1:0] RST_DELAY_TO_OFF  = 16'd1000;
  localparam logic [DataW-1:0] RST_TICK_PERIOD   = 16'd10;

  typedef struct packed {
    logic  lamp_drive;
    logic  lamp_signal;
    mode_t top_mode;
  } result_t;

endpackage
`default_nettype wire

[src/auto_headlamp_mode_controller.sv]
// Headlamp mode controller, stepped once per 10 ms tick item.
// Input channel (in_valid / in_stall) carries the switch position and an
// ambient light reading. Result channel (out_valid / out_stall) returns one
// item per input: lamp drive level, reported lamp state and top mode.
// Configuration channel (cfg_valid / cfg_ready, always ready) writes the
// thresholds, hysteresis delays and tick period by index; write only while
// the block is idle.
// Each result is registered into the output buffer when its input item is accepted.
// Throughput: one item per cycle while in_stall is low; all state is updated
// in a single pass of compare and saturating-add logic between the input and
// the result register. A two-entry output buffer (result register plus skid
// register) lets the block take a new item while a result waits; in_stall
// rises only when both entries hold results that the receiver has not taken.
// Reset (rst_n low, synchronous): block inactive, all lamp levels low,
// timer cleared, registers back to their defaults, output buffer empty.
// The first item after reset only activates the block and enters Off mode.
`timescale 1ns / 1ps
`default_nettype none
module auto_headlamp_mode_controller (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [ahmc_pkg::SwW-1:0]        in_switch_position,
  input  wire logic [ahmc_pkg::DataW-1:0]      in_light_level,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_lamp_drive,
  output logic                                 out_lamp_signal,
  output logic [1:0]                           out_top_mode,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ahmc_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [ahmc_pkg::DataW-1:0]      cfg_data
);

  logic [ahmc_pkg::DataW-1:0] on_thr_r, off_thr_r, dly_on_r, dly_off_r, tick_r;

  ahmc_pkg::mode_t            mode_r, mode_nxt;
  ahmc_pkg::sub_t             sub_r, sub_nxt;
  logic [ahmc_pkg::DataW-1:0] timer_r, timer_nxt;
  logic                       drive_r, drive_nxt;
  logic                       signal_r, signal_nxt;

  logic [ahmc_pkg::DataW:0]   timer_sum;
  logic [ahmc_pkg::DataW-1:0] timer_adv;

  ahmc_pkg::result_t          out_r, skid_r, res_nxt;
  logic                       out_valid_r, skid_valid_r;
  logic                       in_acc, out_pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_pop   = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_thr_r  <= ahmc_pkg::RST_ON_THRESHOLD;
      off_thr_r <= ahmc_pkg::RST_OFF_THRESHOLD;
      dly_on_r  <= ahmc_pkg::RST_DELAY_TO_ON;
      dly_off_r <= ahmc_pkg::RST_DELAY_TO_OFF;
      tick_r    <= ahmc_pkg::RST_TICK_PERIOD;
    end else if (cfg_valid) begin
      case (cfg_index)
        ahmc_pkg::CFG_ON_THRESHOLD:  on_thr_r  <= cfg_data;
        ahmc_pkg::CFG_OFF_THRESHOLD: off_thr_r <= cfg_data;
        ahmc_pkg::CFG_DELAY_TO_ON:   dly_on_r  <= cfg_data;
        ahmc_pkg::CFG_DELAY_TO_OFF:  dly_off_r <= cfg_data;
        ahmc_pkg::CFG_TICK_PERIOD:   tick_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturating timer advance
  assign timer_sum = {1'b0, timer_r} + {1'b0, tick_r};
  assign timer_adv = timer_sum[ahmc_pkg::DataW] ? {ahmc_pkg::DataW{1'b1}}
                                                : timer_sum[ahmc_pkg::DataW-1:0];

  always_comb begin
    mode_nxt   = mode_r;
    sub_nxt    = sub_r;
    timer_nxt  = timer_r;
    drive_nxt  = drive_r;
    signal_nxt = signal_r;
    case (mode_r)
      ahmc_pkg::MODE_INACTIVE: begin
        mode_nxt = ahmc_pkg::MODE_OFF;
      end
      ahmc_pkg::MODE_AUTO: begin
        if (in_switch_position == ahmc_pkg::SW_ON) begin
          sub_nxt  = ahmc_pkg::SUB_NONE;
          mode_nxt = ahmc_pkg::MODE_ON;
        end else if (in_switch_position == ahmc_pkg::SW_OFF) begin
          sub_nxt  = ahmc_pkg::SUB_NONE;
          mode_nxt = ahmc_pkg::MODE_OFF;
        end else begin
          case (sub_r)
            ahmc_pkg::SUB_ENTER: begin
              if (in_light_level > off_thr_r) begin
                sub_nxt   = ahmc_pkg::SUB_OFF;
                drive_nxt = 1'b0;
              end else begin
                sub_nxt   = ahmc_pkg::SUB_ON;
                drive_nxt = 1'b1;
              end
            end
            ahmc_pkg::SUB_OFF: begin
              if (in_light_level < on_thr_r) begin
                sub_nxt   = ahmc_pkg::SUB_TO_ON;
                drive_nxt = 1'b1;
              end else begin
                signal_nxt = 1'b0;
                timer_nxt  = '0;
                drive_nxt  = 1'b0;
              end
            end
            ahmc_pkg::SUB_ON: begin
              if (in_light_level > off_thr_r) begin
                sub_nxt   = ahmc_pkg::SUB_TO_OFF;
                drive_nxt = 1'b0;
              end else begin
                signal_nxt = 1'b1;
                timer_nxt  = '0;
                drive_nxt  = 1'b1;
              end
            end
            ahmc_pkg::SUB_TO_OFF: begin
              if (in_light_level <= off_thr_r) begin
                sub_nxt   = ahmc_pkg::SUB_ON;
                drive_nxt = 1'b1;
              end else if (timer_r >= dly_off_r) begin
                sub_nxt   = ahmc_pkg::SUB_OFF;
                drive_nxt = 1'b0;
              end else begin
                timer_nxt = timer_adv;
                drive_nxt = 1'b0;
              end
            end
            default: begin
              // going on, and any stray code
              if (in_light_level >= on_thr_r) begin
                sub_nxt   = ahmc_pkg::SUB_OFF;
                drive_nxt = 1'b0;
              end else if (timer_r >= dly_on_r) begin
                sub_nxt   = ahmc_pkg::SUB_ON;
                drive_nxt = 1'b1;
              end else begin
                sub_nxt   = ahmc_pkg::SUB_TO_ON;
                timer_nxt = timer_adv;
                drive_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      ahmc_pkg::MODE_OFF: begin
        if (in_switch_position == ahmc_pkg::SW_AUTO) begin
          mode_nxt = ahmc_pkg::MODE_AUTO;
          sub_nxt  = ahmc_pkg::SUB_ENTER;
        end else if (in_switch_position == ahmc_pkg::SW_ON) begin
          mode_nxt = ahmc_pkg::MODE_ON;
        end else begin
          signal_nxt = 1'b0;
          drive_nxt  = 1'b0;
        end
      end
      default: begin
        if (in_switch_position == ahmc_pkg::SW_OFF) begin
          mode_nxt = ahmc_pkg::MODE_OFF;
        end else if (in_switch_position == ahmc_pkg::SW_AUTO) begin
          mode_nxt = ahmc_pkg::MODE_AUTO;
          sub_nxt  = ahmc_pkg::SUB_ENTER;
        end else begin
          signal_nxt = 1'b1;
          drive_nxt  = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    res_nxt.lamp_drive  = drive_nxt;
    res_nxt.lamp_signal = signal_nxt;
    res_nxt.top_mode    = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= ahmc_pkg::MODE_INACTIVE;
      sub_r    <= ahmc_pkg::SUB_NONE;
      timer_r  <= '0;
      drive_r  <= 1'b0;
      signal_r <= 1'b0;
    end else if (in_acc) begin
      mode_r   <= mode_nxt;
      sub_r    <= sub_nxt;
      timer_r  <= timer_nxt;
      drive_r  <= drive_nxt;
      signal_r <= signal_nxt;
    end
  end

  // Output buffer: result register backed by a skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_pop) begin
        if (skid_valid_r) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end else if (in_acc) begin
          out_r <= res_nxt;
        end else begin
          out_valid_r <= 1'b0;
        end
      end else if (in_acc) begin
        if (out_valid_r) begin
          skid_r       <= res_nxt;
          skid_valid_r <= 1'b1;
        end else begin
          out_r       <= res_nxt;
          out_valid_r <= 1'b1;
        end
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_lamp_drive  = out_r.lamp_drive;
  assign out_lamp_signal = out_r.lamp_signal;
  assign out_top_mode    = out_r.top_mode;

endmodule
`default_nettype wire
